// ----- design/psco_pkg.sv -----
// Shared constants and types of the parallel server completion order unit.
package psco_pkg;

    localparam int SERVERS    = 32;
    localparam int ORDER_BITS = 20;
    localparam int TIME_BITS  = 48;
    localparam int DUR_BITS   = 32;
    localparam int CFG_BITS   = 6;
    localparam int CNT_BITS   = $clog2(SERVERS + 1);

    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [ORDER_BITS-1:0] t_job;
    typedef logic [CNT_BITS-1:0]   t_count;

    // Broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic  pop;
        logic  ins;
        t_time ins_time;
        t_job  ins_job;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_INS   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    // Entry a strictly ahead of entry b: earlier end, then smaller job number.
    function automatic logic ahead(t_time ta, t_job ja, t_time tb, t_job jb);
        ahead = (ta < tb) || ((ta == tb) && (ja < jb));
    endfunction

endpackage

// ----- design/psco_job_if.sv -----
// Job channel: duration and last-job flag with valid/ready handshake.
interface psco_job_if;
    logic                          valid;
    logic                          ready;
    logic [psco_pkg::DUR_BITS-1:0] duration;
    logic                          last_job;

    modport source (output valid, output duration, output last_job, input ready);
    modport sink   (input valid, input duration, input last_job, output ready);
endinterface

// ----- design/psco_done_if.sv -----
// Completion channel: job number and end-of-run flag with valid/ready handshake.
interface psco_done_if;
    logic             valid;
    logic             ready;
    psco_pkg::t_job   order_number;
    logic             last_done;

    modport source (output valid, output order_number, output last_done, input ready);
    modport sink   (input valid, input order_number, input last_done, output ready);
endinterface

// ----- design/psco_cell.sv -----
// One cell of the sorted chain: holds one busy server's end time and job number.
module psco_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psco_pkg::t_cell_ctl i_ctl,
    input  logic                i_left_valid,
    input  logic                i_left_ahead,
    input  psco_pkg::t_time     i_left_time,
    input  psco_pkg::t_job      i_left_job,
    input  logic                i_right_valid,
    input  psco_pkg::t_time     i_right_time,
    input  psco_pkg::t_job      i_right_job,
    output logic                o_valid,
    output logic                o_ahead,
    output psco_pkg::t_time     o_time,
    output psco_pkg::t_job      o_job
);

    logic            r_valid;
    psco_pkg::t_time r_time;
    psco_pkg::t_job  r_job;
    logic            n_valid;
    psco_pkg::t_time n_time;
    psco_pkg::t_job  n_job;
    logic            w_ahead;
    logic            w_take;

    // New entry goes ahead of what this cell holds.
    assign w_ahead = psco_pkg::ahead(i_ctl.ins_time, i_ctl.ins_job, r_time, r_job);
    // Empty cell takes part only when it is the first empty one.
    assign w_take  = r_valid ? w_ahead : i_left_valid;

    always_comb begin
        n_valid = r_valid;
        n_time  = r_time;
        n_job   = r_job;
        if (i_ctl.pop) begin
            n_valid = i_right_valid;
            n_time  = i_right_time;
            n_job   = i_right_job;
        end else if (i_ctl.ins && w_take) begin
            n_valid = 1'b1;
            // Shift right behind the insertion point, else land the new entry.
            if (i_left_valid && i_left_ahead) begin
                n_time = i_left_time;
                n_job  = i_left_job;
            end else begin
                n_time = i_ctl.ins_time;
                n_job  = i_ctl.ins_job;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_time <= n_time;
        r_job  <= n_job;
    end

    assign o_valid = r_valid;
    assign o_ahead = r_valid & w_ahead;
    assign o_time  = r_time;
    assign o_job   = r_job;

endmodule

// ----- design/psco_chain.sv -----
// Row of cells kept in completion order; the head is the earliest finisher.
module psco_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psco_pkg::t_cell_ctl i_ctl,
    output logic                o_head_valid,
    output psco_pkg::t_time     o_head_time,
    output psco_pkg::t_job      o_head_job
);

    logic            w_valid [psco_pkg::SERVERS];
    logic            w_ahead [psco_pkg::SERVERS];
    psco_pkg::t_time w_time  [psco_pkg::SERVERS];
    psco_pkg::t_job  w_job   [psco_pkg::SERVERS];

    for (genvar g = 0; g < psco_pkg::SERVERS; g++) begin : g_cell
        logic            w_lv;
        logic            w_la;
        psco_pkg::t_time w_lt;
        psco_pkg::t_job  w_lj;
        logic            w_rv;
        psco_pkg::t_time w_rt;
        psco_pkg::t_job  w_rj;

        if (g == 0) begin : g_first
            assign w_lv = 1'b1;
            assign w_la = 1'b0;
            assign w_lt = '0;
            assign w_lj = '0;
        end else begin : g_mid
            assign w_lv = w_valid[g-1];
            assign w_la = w_ahead[g-1];
            assign w_lt = w_time[g-1];
            assign w_lj = w_job[g-1];
        end

        if (g == psco_pkg::SERVERS - 1) begin : g_end
            assign w_rv = 1'b0;
            assign w_rt = '0;
            assign w_rj = '0;
        end else begin : g_inner
            assign w_rv = w_valid[g+1];
            assign w_rt = w_time[g+1];
            assign w_rj = w_job[g+1];
        end

        psco_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (i_ctl),
            .i_left_valid  (w_lv),
            .i_left_ahead  (w_la),
            .i_left_time   (w_lt),
            .i_left_job    (w_lj),
            .i_right_valid (w_rv),
            .i_right_time  (w_rt),
            .i_right_job   (w_rj),
            .o_valid       (w_valid[g]),
            .o_ahead       (w_ahead[g]),
            .o_time        (w_time[g]),
            .o_job         (w_job[g])
        );
    end

    assign o_head_valid = w_valid[0];
    assign o_head_time  = w_time[0];
    assign o_head_job   = w_job[0];

endmodule

// ----- design/parallel_server_completion_order_unit.sv -----
// Top level: list scheduler reporting job completions in end-time order.
// Each job is accepted and then inserted. On accept, when every server in use is
// busy, the earliest finisher is popped off the head of the sorted cell chain;
// the new end time is its end time, or zero while a server is free, plus the new
// duration. On insertion every cell compares the new entry at once and the chain
// shifts it into place. An accept that has to report a completion waits while
// the output register is full and not taken. A job flagged last is followed by a
// drain of one completion per remaining busy server, each gated by acceptance on
// the completion channel. End times saturate at the time width; job numbers wrap.
module parallel_server_completion_order_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psco_pkg::CFG_BITS-1:0] i_cfg_data,
    psco_job_if.sink                      i_job,
    psco_done_if.source                   o_done
);

    psco_pkg::t_state              r_state, n_state;
    logic [psco_pkg::CFG_BITS-1:0] r_num;
    psco_pkg::t_count              r_busy;
    psco_pkg::t_job                r_seen;
    psco_pkg::t_job                r_ins_job;
    psco_pkg::t_time               r_end;
    logic                          r_last;
    logic                          r_ov;
    psco_pkg::t_job                r_o_job;
    logic                          r_o_last;

    psco_pkg::t_count              w_use;
    logic                          w_need_pop;
    logic                          w_space;
    logic                          w_accept;
    logic                          w_emit;
    logic                          w_drain_emit;
    logic [psco_pkg::TIME_BITS:0]  w_sum;
    psco_pkg::t_time               w_end;
    psco_pkg::t_cell_ctl           w_ctl;
    logic                          w_head_valid;
    psco_pkg::t_time               w_head_time;
    psco_pkg::t_job                w_head_job;

    // Clamp the server count to 1..SERVERS.
    always_comb begin
        if (r_num == '0) begin
            w_use = psco_pkg::t_count'(1);
        end else if (int'(r_num) > psco_pkg::SERVERS) begin
            w_use = psco_pkg::t_count'(psco_pkg::SERVERS);
        end else begin
            w_use = psco_pkg::t_count'(r_num);
        end
    end

    assign w_need_pop   = (r_busy >= w_use);
    assign w_space      = !r_ov || o_done.ready;
    assign i_job.ready  = (r_state == psco_pkg::S_IDLE) && (!w_need_pop || w_space);
    assign w_accept     = i_job.valid && i_job.ready;
    assign w_drain_emit = (r_state == psco_pkg::S_DRAIN) && w_space;
    assign w_emit       = (w_accept && w_need_pop) || w_drain_emit;

    // Start at the popped end time, or at zero while a server is free.
    assign w_sum = {1'b0, (w_need_pop ? w_head_time : psco_pkg::t_time'(0))}
                 + {{(psco_pkg::TIME_BITS + 1 - psco_pkg::DUR_BITS){1'b0}}, i_job.duration};
    assign w_end = w_sum[psco_pkg::TIME_BITS] ? '1 : w_sum[psco_pkg::TIME_BITS-1:0];

    always_comb begin
        w_ctl.pop      = w_emit;
        w_ctl.ins      = (r_state == psco_pkg::S_INS);
        w_ctl.ins_time = r_end;
        w_ctl.ins_job  = r_ins_job;
    end

    psco_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_head_valid (w_head_valid),
        .o_head_time  (w_head_time),
        .o_head_job   (w_head_job)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psco_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = psco_pkg::S_INS;
                end
            end
            psco_pkg::S_INS: begin
                n_state = r_last ? psco_pkg::S_DRAIN : psco_pkg::S_IDLE;
            end
            psco_pkg::S_DRAIN: begin
                if (w_drain_emit && r_busy == psco_pkg::t_count'(1)) begin
                    n_state = psco_pkg::S_IDLE;
                end
            end
            default: n_state = psco_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psco_pkg::S_IDLE;
            r_num   <= psco_pkg::CFG_BITS'(1);
            r_busy  <= '0;
            r_seen  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_num <= i_cfg_data;
            end
            if (w_ctl.ins) begin
                r_busy <= r_busy + psco_pkg::t_count'(1);
            end else if (w_emit) begin
                r_busy <= r_busy - psco_pkg::t_count'(1);
            end
            if (w_accept) begin
                r_seen <= r_seen + psco_pkg::t_job'(1);
            end else if (w_ctl.ins && r_last) begin
                r_seen <= '0;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_done.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_end     <= w_end;
            r_ins_job <= r_seen + psco_pkg::t_job'(1);
            r_last    <= i_job.last_job;
        end
        if (w_emit) begin
            r_o_job  <= w_head_job;
            r_o_last <= w_drain_emit && (r_busy == psco_pkg::t_count'(1));
        end
    end

    assign o_done.valid        = r_ov;
    assign o_done.order_number = r_o_job;
    assign o_done.last_done    = r_o_last;

    // Occupancy count and the chain's head cell agree.
    a_busy_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy != '0) == w_head_valid)
        else $error("busy count and chain head disagree");

    a_busy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_busy) <= psco_pkg::SERVERS)
        else $error("busy count above server count");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psco_pkg::S_INS && r_last) |=> (r_state == psco_pkg::S_DRAIN))
        else $error("last job did not start the drain");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_drain_emit && r_busy == psco_pkg::t_count'(1))
        |=> (r_busy == '0 && r_state == psco_pkg::S_IDLE && r_seen == '0
             && r_ov && r_o_last))
        else $error("drain did not end cleanly");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_head_valid)
        else $error("pop from empty chain");

endmodule
